### rtl/kct_pkg.sv
package kct_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MaxKeyLenDef = 8;
  localparam int CountBitsDef = 32;

  // Key length after reset.
  localparam logic [3:0] KeyLenReset = 4'd8;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_COUNT  = 3'd0,
    CMD_INC    = 3'd1,
    CMD_DEC    = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_STREAM = 3'd5
  } cmd_e;

  // Result status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StSat     = 2'd1;
  localparam logic [1:0] StClamp   = 2'd2;
  localparam logic [1:0] StWinFill = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WB1,
    S_RD2,
    S_WB2,
    S_HOLD
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;     // write zero at the clearing address
    logic accept;     // capture an input item and read its counter
    logic rd_rc;      // read the reverse complement counter
    logic wb;         // write back the updated counter
    logic phase2;     // write back belongs to the second update of a count
    logic load_now;   // load the output register from the write back result
    logic load_hold;  // load the output register from the held result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic is_count;   // current item is a count command
    logic out_free;   // output register can take a result this cycle
  } ctrl_stat_t;

endpackage

### rtl/kct_ctrl.sv
module kct_ctrl import kct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WB1;
        end
      end
      S_WB1: begin
        if (stat_i.is_count) begin
          state_d = S_RD2;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_RD2: begin
        state_d = S_WB2;
      end
      S_WB2: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_WB1: begin
        cmd_o.wb       = 1'b1;
        cmd_o.load_now = !stat_i.is_count && stat_i.out_free;
      end
      S_RD2: begin
        cmd_o.rd_rc = 1'b1;
      end
      S_WB2: begin
        cmd_o.wb       = 1'b1;
        cmd_o.phase2   = 1'b1;
        cmd_o.load_now = stat_i.out_free;
      end
      S_HOLD: begin
        cmd_o.load_hold = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### rtl/kct_dpath.sv
module kct_dpath import kct_pkg::*; #(
  parameter int MAX_KEY_LEN = MaxKeyLenDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_stat_t            stat_o,
  input  logic                  cfg_valid_i,
  input  logic [3:0]            key_length_i,
  input  logic [2:0]            cmd_in_i,
  input  logic [15:0]           kmer_code_i,
  input  logic [31:0]           write_value_i,
  input  logic [1:0]            base_i,
  input  logic                  first_of_run_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_BITS-1:0] count_o,
  output logic [15:0]           kmer_index_o,
  output logic [1:0]            status_o
);

  localparam int IDX_W = 2 * MAX_KEY_LEN;
  localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);
  localparam longint unsigned DEPTH = 64'd1 << IDX_W;
  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration and window state.
  logic [3:0]       key_length_q;
  logic [IDX_W-1:0] win_code_q, win_code_d;
  logic [LEN_W-1:0] win_fill_q, win_fill_d;
  logic [IDX_W-1:0] clr_cnt_q;

  // Captured item.
  cmd_e             op_q;
  logic [IDX_W-1:0] idx_q, rc_q;
  logic [31:0]      wv_q;
  logic             win_full_q;

  // Table memory and its read data.
  logic [COUNT_BITS-1:0] table_mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [IDX_W-1:0]      mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_we, mem_re;

  // Held and output results.
  logic [COUNT_BITS-1:0] hold_cnt_q, out_cnt_q;
  logic [IDX_W-1:0]      hold_idx_q, out_idx_q;
  logic [1:0]            hold_st_q, out_st_q;
  logic                  out_valid_q;

  // Accept-time values.
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] mask, idx_in, x_in, rc_in, acc_addr;
  logic [IDX_W-1:0] win_base;
  logic [LEN_W-1:0] fill_base;
  logic             win_full;

  // Write back values.
  logic                  sat;
  logic [COUNT_BITS-1:0] bump_val;
  logic                  wr;
  logic [COUNT_BITS-1:0] new_val;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [IDX_W-1:0]      res_idx;
  logic [1:0]            res_st;

  // Key length clamped into the supported range.
  always_comb begin
    if (key_length_q == 4'd0) begin
      len_eff = LEN_W'(1);
    end else if (int'(key_length_q) > MAX_KEY_LEN) begin
      len_eff = LEN_W'(MAX_KEY_LEN);
    end else begin
      len_eff = LEN_W'(key_length_q);
    end
  end

  // Digit mask and the forward code of the incoming k-mer.
  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      mask[2*i +: 2] = (i < int'(len_eff)) ? 2'b11 : 2'b00;
    end
  end

  assign idx_in = IDX_W'(kmer_code_i) & mask;
  assign x_in   = idx_in ^ mask;

  // Reverse complement: digit j takes complemented digit len-1-j.
  always_comb begin
    rc_in = '0;
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      for (int k = 0; k < MAX_KEY_LEN; k++) begin
        if ((j < int'(len_eff)) && (k == int'(len_eff) - 1 - j)) begin
          rc_in[2*j +: 2] = x_in[2*k +: 2];
        end
      end
    end
  end

  // Sliding window after shifting in the streamed base.
  always_comb begin
    win_base   = first_of_run_i ? '0 : win_code_q;
    fill_base  = first_of_run_i ? '0 : win_fill_q;
    win_code_d = (win_base << 2) | IDX_W'(base_i);
    if (int'(fill_base) < MAX_KEY_LEN) begin
      win_fill_d = fill_base + LEN_W'(1);
    end else begin
      win_fill_d = fill_base;
    end
    win_full = (win_fill_d >= len_eff);
    acc_addr = (cmd_e'(cmd_in_i) == CMD_STREAM) ? (win_code_d & mask) : idx_in;
  end

  // Configuration register and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KeyLenReset;
      win_code_q   <= '0;
      win_fill_q   <= '0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        key_length_q <= key_length_i;
      end
      if (cmd_i.accept && (cmd_e'(cmd_in_i) == CMD_STREAM)) begin
        win_code_q <= win_code_d;
        win_fill_q <= win_fill_d;
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (cmd_i.load_now || cmd_i.load_hold) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture of an accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= cmd_e'(cmd_in_i);
      idx_q      <= acc_addr;
      rc_q       <= rc_in;
      wv_q       <= write_value_i;
      win_full_q <= win_full;
    end
  end

  // Update of the counter that was read.
  assign sat      = &rdata_q;
  assign bump_val = sat ? rdata_q : rdata_q + COUNT_BITS'(1);

  always_comb begin
    wr      = 1'b0;
    new_val = rdata_q;
    res_cnt = '0;
    res_idx = idx_q;
    res_st  = StOk;
    if (cmd_i.phase2) begin
      wr      = 1'b1;
      new_val = bump_val;
      res_st  = hold_st_q | (sat ? StSat : StOk);
      res_cnt = (rc_q == idx_q) ? bump_val : hold_cnt_q;
    end else begin
      case (op_q)
        CMD_COUNT, CMD_INC: begin
          wr      = 1'b1;
          new_val = bump_val;
          res_cnt = bump_val;
          res_st  = sat ? StSat : StOk;
        end
        CMD_DEC: begin
          if (rdata_q == '0) begin
            res_st = StClamp;
          end else begin
            wr      = 1'b1;
            new_val = rdata_q - COUNT_BITS'(1);
          end
          res_cnt = new_val;
        end
        CMD_WRITE: begin
          wr = 1'b1;
          if (CMP_W'(wv_q) > CMP_W'(COUNT_MAX)) begin
            new_val = COUNT_MAX;
            res_st  = StSat;
          end else begin
            new_val = COUNT_BITS'(wv_q);
          end
          res_cnt = new_val;
        end
        CMD_READ: begin
          res_cnt = rdata_q;
        end
        CMD_STREAM: begin
          if (win_full_q) begin
            wr      = 1'b1;
            new_val = bump_val;
            res_cnt = bump_val;
            res_st  = sat ? StSat : StOk;
          end else begin
            res_idx = '0;
            res_st  = StWinFill;
          end
        end
        default: begin
          res_idx = '0;
        end
      endcase
    end
  end

  // Single port of the table: clearing pass, reads and write backs.
  always_comb begin
    if (cmd_i.clr_en) begin
      mem_addr = clr_cnt_q;
    end else if (cmd_i.accept) begin
      mem_addr = acc_addr;
    end else if (cmd_i.rd_rc || cmd_i.phase2) begin
      mem_addr = rc_q;
    end else begin
      mem_addr = idx_q;
    end
    mem_we    = cmd_i.clr_en || (cmd_i.wb && wr);
    mem_re    = cmd_i.accept || cmd_i.rd_rc;
    mem_wdata = cmd_i.clr_en ? '0 : new_val;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= table_mem[mem_addr];
    end
  end

  // Held result and output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      hold_cnt_q <= res_cnt;
      hold_idx_q <= res_idx;
      hold_st_q  <= res_st;
    end
    if (cmd_i.load_now) begin
      out_cnt_q <= res_cnt;
      out_idx_q <= res_idx;
      out_st_q  <= res_st;
    end else if (cmd_i.load_hold) begin
      out_cnt_q <= hold_cnt_q;
      out_idx_q <= hold_idx_q;
      out_st_q  <= hold_st_q;
    end
  end

  // Status back to the controller.
  assign stat_o.clr_last = &clr_cnt_q;
  assign stat_o.is_count = (op_q == CMD_COUNT);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign count_o      = out_cnt_q;
  assign kmer_index_o = 16'(out_idx_q);
  assign status_o     = out_st_q;

endmodule

### rtl/kmer_count_table.sv
// A result enters the output register at its item's write back (the second for a count)
// or, if the output stalls, from the held copy once it frees. No new item is taken till
// then; the single table port does one read and one write per update, two for a count.
// Reset: asynchronous, active low; key length returns to 8 and the window empties.
// After reset a clearing pass zeroes all 4^MAX_KEY_LEN table entries (65536 by default),
// during which no item is accepted; configuration writes are taken at all times.
module kmer_count_table import kct_pkg::*; #(
  parameter int MAX_KEY_LEN = MaxKeyLenDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [3:0]            key_length_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            cmd_i,
  input  logic [15:0]           kmer_code_i,
  input  logic [31:0]           write_value_i,
  input  logic [1:0]            base_i,
  input  logic                  first_of_run_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_BITS-1:0] count_o,
  output logic [15:0]           kmer_index_o,
  output logic [1:0]            status_o
);

  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  // The key length register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer for clearing, read and write back steps.
  kct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (ctrl_stat),
    .cmd_o      (ctrl_cmd)
  );

  // Table, window and result registers.
  kct_dpath #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (ctrl_stat),
    .cfg_valid_i    (cfg_valid_i),
    .key_length_i   (key_length_i),
    .cmd_in_i       (cmd_i),
    .kmer_code_i    (kmer_code_i),
    .write_value_i  (write_value_i),
    .base_i         (base_i),
    .first_of_run_i (first_of_run_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .count_o        (count_o),
    .kmer_index_o   (kmer_index_o),
    .status_o       (status_o)
  );

endmodule
